### rtl/core/cia_pkg.sv
// Shared types and constants of the compressed instruction aligner.
package cia_pkg;

   localparam int HW_W     = 16;  // one instruction parcel
   localparam int ADDR_W   = 32;
   localparam int WORD_W   = 32;
   localparam int FETCH_HW = 4;   // halfwords carried by one fetch request
   localparam int WINDOW   = 4;   // halfwords looked at per request
   localparam int USED_W   = 3;   // up to WINDOW halfwords retired per request
   localparam int FSLOT_W  = 3;

   // low bits of a halfword that mark a full 32-bit instruction
   localparam logic [1:0] FULL_WORD_CODE = 2'b11;

   localparam logic [ADDR_W-1:0] HALF_BYTES = ADDR_W'(2);
   localparam logic [ADDR_W-1:0] WORD_BYTES = ADDR_W'(4);

   typedef enum logic [0:0] {
      CSR_FIRST_ENABLE  = 1'b0,
      CSR_SECOND_ENABLE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                      thread_id;
      logic                      fetch_valid;
      logic [FSLOT_W-1:0]        fetch_slots;
      logic [ADDR_W-1:0]         fetch_addr;
      logic [FETCH_HW*HW_W-1:0]  fetch_data;
   } cia_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] first_word;
      logic [ADDR_W-1:0] first_address;
      logic              first_compressed;
      logic              first_valid;
      logic [WORD_W-1:0] second_word;
      logic [ADDR_W-1:0] second_address;
      logic              second_compressed;
      logic              second_valid;
      logic              consume_one;
      logic              consume_two;
   } cia_rsp_type;

   // queue update command for one thread
   typedef struct packed {
      logic                      step;
      logic [USED_W-1:0]         used;
      logic                      fill;
      logic [FSLOT_W-1:0]        fill_slots;
      logic [ADDR_W-1:0]         fill_addr;
      logic [FETCH_HW*HW_W-1:0]  fill_data;
   } cia_update_type;

endpackage

### rtl/core/cia_if.sv
// Valid/ready channel interfaces for aligner requests and results.
interface cia_req_if import cia_pkg::*;;
   logic        valid;
   logic        ready;
   cia_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cia_rsp_if import cia_pkg::*;;
   logic        valid;
   logic        ready;
   cia_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/compressed_instruction_aligner.sv
// Top level of the compressed instruction aligner.
// A request is held in the request register, then moves into the result register.
// Throughput: one request per cycle unless the result stalls; the queue update sets this.
// Reset (synchronous): all thread queues empty, first_enable 1, second_enable 0,
// request and result registers empty.
module compressed_instruction_aligner import cia_pkg::*; #(
   parameter int THREADS = 2,
   parameter int BLOCKS  = 4,
   parameter int SLOTS   = 4
) (
   input  logic              clock,
   input  logic              reset,
   cia_req_if.sink           req_chan,
   cia_rsp_if.source         rsp_chan,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic              csr_write_data
);

   localparam int CNT_W = $clog2(SLOTS+1);

   // request register and result register
   logic        req_valid_ff, req_valid_in;
   cia_req_type req_payload_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   cia_rsp_type rsp_payload_ff;

   logic first_enable_ff, second_enable_ff;

   logic advance;
   logic thread_ok;

   // front views of every thread's queue
   logic [SLOTS-1:0][HW_W-1:0] q_blk0  [THREADS];
   logic [SLOTS-1:0][HW_W-1:0] q_blk1  [THREADS];
   logic [CNT_W-1:0]           q_cnt0  [THREADS];
   logic [CNT_W-1:0]           q_cnt1  [THREADS];
   logic [ADDR_W-1:0]          q_base  [THREADS];
   cia_update_type             q_upd   [THREADS];

   // view of the thread being served
   logic [SLOTS-1:0][HW_W-1:0] sel_blk0, sel_blk1;
   logic [CNT_W-1:0]           sel_cnt0, sel_cnt1;
   logic [ADDR_W-1:0]          sel_base;

   cia_rsp_type       rsp_next;
   logic [USED_W-1:0] used;

   // Configuration: to be written only while idle (the block does not enforce this), so take it directly.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_enable_ff  <= 1'b1;
         second_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIRST_ENABLE:  first_enable_ff  <= csr_write_data;
            CSR_SECOND_ENABLE: second_enable_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Advance the held request into the result register whenever the result
   // slot is free or is being taken this cycle. The request register then
   // refills in the same cycle, so one request a cycle flows through; while
   // the result is stalled one further request can still be taken and held.
   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_payload_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_payload_ff <= rsp_next;
      end
   end

   // A thread number beyond the configured count sees an empty queue: the
   // result is all zero and no queue is touched.
   assign thread_ok = int'(req_payload_ff.thread_id) < THREADS;

   always_comb begin
      sel_blk0 = '0;
      sel_blk1 = '0;
      sel_cnt0 = '0;
      sel_cnt1 = '0;
      sel_base = '0;
      for (int t = 0; t < THREADS; t++) begin
         if (t == int'(req_payload_ff.thread_id)) begin
            sel_blk0 = q_blk0[t];
            sel_blk1 = q_blk1[t];
            sel_cnt0 = q_cnt0[t];
            sel_cnt1 = q_cnt1[t];
            sel_base = q_base[t];
         end
      end
   end

   // Decode the first one or two instructions from the served thread's window.
   cia_align #(
      .SLOTS (SLOTS)
   ) u_align (
      .blk0_slots_i    (sel_blk0),
      .blk1_slots_i    (sel_blk1),
      .count0_i        (sel_cnt0),
      .count1_i        (sel_cnt1),
      .base_addr_i     (sel_base),
      .first_enable_i  (first_enable_ff),
      .second_enable_i (second_enable_ff),
      .rsp_o           (rsp_next),
      .used_o          (used)
   );

   // One queue per thread; only the served thread updates, and it does so in
   // the cycle its request moves to the result register, so a following
   // request for the same thread sees the retired and refilled queue.
   for (genvar t = 0; t < THREADS; t++) begin : g_thread
      always_comb begin
         q_upd[t].step       = advance && thread_ok &&
                               (t == int'(req_payload_ff.thread_id));
         q_upd[t].used       = used;
         q_upd[t].fill       = req_payload_ff.fetch_valid;
         q_upd[t].fill_slots = req_payload_ff.fetch_slots;
         q_upd[t].fill_addr  = req_payload_ff.fetch_addr;
         q_upd[t].fill_data  = req_payload_ff.fetch_data;
      end

      cia_queue #(
         .BLOCKS (BLOCKS),
         .SLOTS  (SLOTS)
      ) u_queue (
         .clock        (clock),
         .reset        (reset),
         .upd_i        (q_upd[t]),
         .blk0_slots_o (q_blk0[t]),
         .blk1_slots_o (q_blk1[t]),
         .count0_o     (q_cnt0[t]),
         .count1_o     (q_cnt1[t]),
         .base_addr_o  (q_base[t])
      );
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

### rtl/core/cia_align.sv
// Window assembly and instruction boundary decode over the two front blocks.
module cia_align import cia_pkg::*; #(
   parameter int SLOTS = 4
) (
   input  logic [SLOTS-1:0][HW_W-1:0]    blk0_slots_i,
   input  logic [SLOTS-1:0][HW_W-1:0]    blk1_slots_i,
   input  logic [$clog2(SLOTS+1)-1:0]    count0_i,
   input  logic [$clog2(SLOTS+1)-1:0]    count1_i,
   input  logic [ADDR_W-1:0]             base_addr_i,
   input  logic                          first_enable_i,
   input  logic                          second_enable_i,
   output cia_rsp_type                   rsp_o,
   output logic [USED_W-1:0]             used_o
);

   localparam int CNT_W  = $clog2(SLOTS+1);
   localparam int SIDX_W = $clog2(SLOTS);
   localparam int CW     = (CNT_W > USED_W) ? CNT_W : USED_W;

   logic [HW_W-1:0] win [WINDOW];
   logic            win_v [WINDOW];
   logic [2:0]      k;
   logic            cmp0, cmp1, v0, v1;
   logic [HW_W-1:0] w_i1, w_i1p;
   logic            wv_i1, wv_i1p;
   logic [CW-1:0]   used_w, c0_w, c1_w;

   // pack block 0's valid slots, then block 1's
   always_comb begin
      k = '0;
      for (int j = 0; j < WINDOW; j++) begin
         win[j]   = '0;
         win_v[j] = 1'b0;
         if (CNT_W'(j) < count0_i) begin
            win[j]   = blk0_slots_i[SIDX_W'(j)];
            win_v[j] = 1'b1;
         end else begin
            k = 3'(j) - 3'(count0_i);
            if (CNT_W'(k) < count1_i) begin
               win[j]   = blk1_slots_i[SIDX_W'(k)];
               win_v[j] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      cmp0   = win_v[0] && (win[0][1:0] != FULL_WORD_CODE);
      v0     = win_v[0] && (cmp0 || win_v[1]) && first_enable_i;
      w_i1   = cmp0 ? win[1]   : win[2];
      wv_i1  = cmp0 ? win_v[1] : win_v[2];
      w_i1p  = cmp0 ? win[2]   : win[3];
      wv_i1p = cmp0 ? win_v[2] : win_v[3];
      cmp1   = wv_i1 && (w_i1[1:0] != FULL_WORD_CODE);
      v1     = v0 && wv_i1 && (cmp1 || wv_i1p) && second_enable_i;

      used_o = '0;
      if (v0) begin
         used_o = cmp0 ? USED_W'(1) : USED_W'(2);
         if (v1) begin
            used_o = used_o + (cmp1 ? USED_W'(1) : USED_W'(2));
         end
      end

      used_w = CW'(used_o);
      c0_w   = CW'(count0_i);
      c1_w   = CW'(count1_i);

      rsp_o = '0;
      if (v0) begin
         rsp_o.first_word       = cmp0 ? {{HW_W{1'b0}}, win[0]} : {win[1], win[0]};
         rsp_o.first_address    = base_addr_i;
         rsp_o.first_compressed = cmp0;
         rsp_o.first_valid      = 1'b1;
      end
      if (v1) begin
         rsp_o.second_word       = cmp1 ? {{HW_W{1'b0}}, w_i1} : {w_i1p, w_i1};
         rsp_o.second_address    = base_addr_i + (cmp0 ? HALF_BYTES : WORD_BYTES);
         rsp_o.second_compressed = cmp1;
         rsp_o.second_valid      = 1'b1;
      end
      rsp_o.consume_one = (used_w != '0) && (used_w >= c0_w);
      rsp_o.consume_two = rsp_o.consume_one && ((used_w - c0_w) >= c1_w);
   end

endmodule

### rtl/core/cia_queue.sv
// Fetch block queue of one thread: retire, compact and fill.
module cia_queue import cia_pkg::*; #(
   parameter int BLOCKS = 4,
   parameter int SLOTS  = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cia_update_type                upd_i,
   output logic [SLOTS-1:0][HW_W-1:0]    blk0_slots_o,
   output logic [SLOTS-1:0][HW_W-1:0]    blk1_slots_o,
   output logic [$clog2(SLOTS+1)-1:0]    count0_o,
   output logic [$clog2(SLOTS+1)-1:0]    count1_o,
   output logic [ADDR_W-1:0]             base_addr_o
);

   localparam int CNT_W    = $clog2(SLOTS+1);
   localparam int SIDX_W   = $clog2(SLOTS);
   localparam int CW       = (CNT_W > USED_W) ? CNT_W : USED_W;
   localparam int FILL_MAX = (SLOTS < FETCH_HW) ? SLOTS : FETCH_HW;

   typedef struct packed {
      logic [SLOTS-1:0][HW_W-1:0] slots;
      logic [CNT_W-1:0]           count;
      logic [ADDR_W-1:0]          addr;
   } blk_type;

   blk_type blk_ff  [BLOCKS];
   blk_type blk_in  [BLOCKS];
   blk_type cons    [BLOCKS];
   blk_type shifted [BLOCKS];
   blk_type fresh;

   logic [CW-1:0]      used_w, c0_w;
   logic               sh_one, sh_two, found, do_fill;
   logic [FSLOT_W-1:0] fill_cnt;

   // retire k slots from the front of a block; empty it when none remain
   function automatic blk_type drop_block(blk_type blk, logic [CW-1:0] k);
      blk_type   res;
      logic [CW:0] idx;
      res = blk;
      if (k != '0) begin
         if (k >= CW'(blk.count)) begin
            res = '0;
         end else begin
            for (int i = 0; i < SLOTS; i++) begin
               idx = (CW+1)'(i) + (CW+1)'(k);
               res.slots[i] = (idx < (CW+1)'(SLOTS)) ? blk.slots[SIDX_W'(idx)] : '0;
            end
            res.count = blk.count - CNT_W'(k);
            res.addr  = blk.addr + (ADDR_W'(k) << 1);
         end
      end
      return res;
   endfunction

   always_comb begin
      used_w = CW'(upd_i.used);
      c0_w   = CW'(blk_ff[0].count);
      for (int b = 0; b < BLOCKS; b++) begin
         cons[b] = blk_ff[b];
      end
      if (used_w != '0) begin
         if (used_w >= c0_w) begin
            cons[0] = '0;
            cons[1] = drop_block(blk_ff[1], used_w - c0_w);
         end else begin
            cons[0] = drop_block(blk_ff[0], used_w);
         end
      end

      // compact empty front blocks away
      sh_two = (cons[0].count == '0) && (cons[1].count == '0);
      sh_one = (cons[0].count == '0) && !sh_two;
      for (int b = 0; b < BLOCKS; b++) begin
         if (sh_two) begin
            shifted[b] = (b + 2 < BLOCKS) ? cons[(b + 2) % BLOCKS] : '0;
         end else if (sh_one) begin
            shifted[b] = (b + 1 < BLOCKS) ? cons[(b + 1) % BLOCKS] : '0;
         end else begin
            shifted[b] = cons[b];
         end
      end

      // new block into the first empty entry, dropped when the queue is full
      fill_cnt = (upd_i.fill_slots > FSLOT_W'(FILL_MAX)) ? FSLOT_W'(FILL_MAX)
                                                         : upd_i.fill_slots;
      do_fill  = upd_i.fill && (fill_cnt != '0);
      fresh    = '0;
      for (int j = 0; j < FILL_MAX; j++) begin
         if (FSLOT_W'(j) < fill_cnt) begin
            fresh.slots[j] = upd_i.fill_data[j*HW_W +: HW_W];
         end
      end
      fresh.count = CNT_W'(fill_cnt);
      fresh.addr  = upd_i.fill_addr;

      found = 1'b0;
      for (int b = 0; b < BLOCKS; b++) begin
         blk_in[b] = shifted[b];
         if (!found && (shifted[b].count == '0)) begin
            found = 1'b1;
            if (do_fill) begin
               blk_in[b] = fresh;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < BLOCKS; b++) begin
         if (reset) begin
            blk_ff[b] <= '0;
         end else if (upd_i.step) begin
            blk_ff[b] <= blk_in[b];
         end
      end
   end

   assign blk0_slots_o = blk_ff[0].slots;
   assign blk1_slots_o = blk_ff[1].slots;
   assign count0_o     = blk_ff[0].count;
   assign count1_o     = blk_ff[1].count;
   assign base_addr_o  = blk_ff[0].addr;

endmodule
